@@ design/via_pkg.sv @@
// via_pkg: shared codes and reset values for the versatile interface adapter
// no dependencies; used by versatile_interface_timers_shift_irq
package via_pkg;

	// request kinds
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// register offsets
	localparam logic [3:0] REG_PB     = 4'd0;
	localparam logic [3:0] REG_PA     = 4'd1;
	localparam logic [3:0] REG_DDRB   = 4'd2;
	localparam logic [3:0] REG_DDRA   = 4'd3;
	localparam logic [3:0] REG_T1CL   = 4'd4;
	localparam logic [3:0] REG_T1CH   = 4'd5;
	localparam logic [3:0] REG_T1LL   = 4'd6;
	localparam logic [3:0] REG_T1LH   = 4'd7;
	localparam logic [3:0] REG_T2CL   = 4'd8;
	localparam logic [3:0] REG_T2CH   = 4'd9;
	localparam logic [3:0] REG_SR     = 4'd10;
	localparam logic [3:0] REG_ACR    = 4'd11;
	localparam logic [3:0] REG_PCR    = 4'd12;
	localparam logic [3:0] REG_IFR    = 4'd13;
	localparam logic [3:0] REG_IER    = 4'd14;
	localparam logic [3:0] REG_PA_NH  = 4'd15;

	// interrupt flag bits
	localparam int FLAG_CA2 = 0;
	localparam int FLAG_CA1 = 1;
	localparam int FLAG_SR  = 2;
	localparam int FLAG_CB2 = 3;
	localparam int FLAG_CB1 = 4;
	localparam int FLAG_T2  = 5;
	localparam int FLAG_T1  = 6;

	// shift modes, aux control bits 4..2
	localparam logic [2:0] SR_FREE_T2 = 3'b100;
	localparam logic [2:0] SR_OFF     = 3'b000;

	// shift clock source, aux control bits 3..2
	localparam logic [1:0] SR_CLK_T2  = 2'b01;
	localparam logic [1:0] SR_CLK_SYS = 2'b10;

	// pcr bits 3..1 that pull ca2 low
	localparam logic [2:0] CA2_LOW_OUT = 3'b110;

	localparam logic [15:0] TIMER_RESET = 16'hffff;
	localparam logic [7:0]  LATCH_RESET = 8'hff;
	localparam logic [3:0]  SHIFT_IN_COUNT  = 4'd8;
	localparam logic [3:0]  SHIFT_OUT_COUNT = 4'd9;
	localparam logic [3:0]  SHIFT_MAX_COUNT = 4'd9;

endpackage

@@ design/versatile_interface_timers_shift_irq.sv @@
// versatile_interface_timers_shift_irq: two ports, two timers, shift register, interrupts
// depends on via_pkg
//
// Each request (tick, register read or register write) is taken into an input register,
// worked through one pass of update logic and written with the new state into a result
// register. One request is accepted every clock cycle while the result register is empty
// or being taken, and its result is offered from the result register. While a result waits
// to be taken one more request can enter the input register, after which the input stalls
// until the result is taken. The result carries read data (zero for ticks and writes) and
// the port, irq, CA2 and CB2 levels after the request. Opcode 3 behaves as a tick.
module versatile_interface_timers_shift_irq (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [3:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic [7:0] port_a_pins,
	input  logic [7:0] port_b_pins,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       irq,
	output logic [7:0] port_a_drive,
	output logic [7:0] port_a_dir,
	output logic [7:0] port_b_drive,
	output logic [7:0] port_b_dir,
	output logic       ca2_level,
	output logic       cb2_level
);

	// input stage
	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [3:0] reg_addr_s1;
	logic [7:0] write_data_s1;
	logic [7:0] pa_s1;
	logic [7:0] pb_s1;

	// architectural state
	logic [7:0]  dir_a_q, dir_b_q, out_a_q, out_b_q;
	logic [15:0] t1_count_q, t1_latch_q, t2_count_q;
	logic        t1_reload_q, t1_armed_q, t2_reload_q, t2_armed_q;
	logic [7:0]  t2_latch_low_q;
	logic [7:0]  sr_value_q;
	logic [3:0]  sr_left_q;
	logic        sr_start_q;
	logic [7:0]  acr_q, pcr_q;
	logic [6:0]  ifr_q, ier_q;
	logic        sr_phase_q, sr_out_q;

	// result register
	logic       valid_s2;
	logic [7:0] read_data_s2;
	logic       irq_s2;
	logic       ca2_s2;

	logic advance;
	logic step;

	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// next state
	logic [7:0]  n_dir_a, n_dir_b, n_out_a, n_out_b;
	logic [15:0] n_t1_count, n_t1_latch, n_t2_count;
	logic        n_t1_reload, n_t1_armed, n_t2_reload, n_t2_armed;
	logic [7:0]  n_t2_latch_low;
	logic [7:0]  n_sr_value;
	logic [3:0]  n_sr_left;
	logic        n_sr_start;
	logic [7:0]  n_acr, n_pcr;
	logic [6:0]  n_ifr, n_ier;
	logic        n_sr_phase, n_sr_out;
	logic [7:0]  n_rd;
	logic [7:0]  pa_read, pb_read;
	logic        any_irq;

	assign pa_read = (pa_s1 & ~dir_a_q) | (out_a_q & dir_a_q);
	assign pb_read = (pb_s1 & ~dir_b_q) | (out_b_q & dir_b_q);
	assign any_irq = |(ifr_q & ier_q);

	always_comb begin
		logic [3:0] left_dec;
		n_dir_a        = dir_a_q;
		n_dir_b        = dir_b_q;
		n_out_a        = out_a_q;
		n_out_b        = out_b_q;
		n_t1_count     = t1_count_q;
		n_t1_latch     = t1_latch_q;
		n_t2_count     = t2_count_q;
		n_t1_reload    = t1_reload_q;
		n_t1_armed     = t1_armed_q;
		n_t2_reload    = t2_reload_q;
		n_t2_armed     = t2_armed_q;
		n_t2_latch_low = t2_latch_low_q;
		n_sr_value     = sr_value_q;
		n_sr_left      = sr_left_q;
		n_sr_start     = sr_start_q;
		n_acr          = acr_q;
		n_pcr          = pcr_q;
		n_ifr          = ifr_q;
		n_ier          = ier_q;
		n_sr_phase     = sr_phase_q;
		n_sr_out       = sr_out_q;
		n_rd           = 8'h00;
		left_dec       = sr_left_q - 4'd1;

		case (opcode_s1)
			via_pkg::OP_READ: begin
				unique case (reg_addr_s1)
					via_pkg::REG_PB: begin
						if ((pcr_q & 8'ha0) != 8'h20)
							n_ifr[via_pkg::FLAG_CB2] = 1'b0;
						n_ifr[via_pkg::FLAG_CB1] = 1'b0;
						n_rd = pb_read;
					end
					via_pkg::REG_PA: begin
						if ((pcr_q & 8'h0a) != 8'h02)
							n_ifr[via_pkg::FLAG_CA2] = 1'b0;
						n_ifr[via_pkg::FLAG_CA1] = 1'b0;
						n_rd = pa_read;
					end
					via_pkg::REG_DDRB: n_rd = dir_b_q;
					via_pkg::REG_DDRA: n_rd = dir_a_q;
					via_pkg::REG_T1CL: begin
						n_ifr[via_pkg::FLAG_T1] = 1'b0;
						n_rd = t1_count_q[7:0];
					end
					via_pkg::REG_T1CH: n_rd = t1_count_q[15:8];
					via_pkg::REG_T1LL: n_rd = t1_latch_q[7:0];
					via_pkg::REG_T1LH: n_rd = t1_latch_q[15:8];
					via_pkg::REG_T2CL: begin
						n_ifr[via_pkg::FLAG_T2] = 1'b0;
						n_rd = t2_count_q[7:0];
					end
					via_pkg::REG_T2CH: n_rd = t2_count_q[15:8];
					via_pkg::REG_SR: begin
						n_ifr[via_pkg::FLAG_SR] = 1'b0;
						if ((acr_q[4:2] != via_pkg::SR_OFF) && (sr_left_q == 4'd0))
							n_sr_start = 1'b1;
						n_rd = sr_value_q;
					end
					via_pkg::REG_ACR: n_rd = acr_q;
					via_pkg::REG_PCR: n_rd = pcr_q;
					via_pkg::REG_IFR: n_rd = {any_irq, ifr_q};
					via_pkg::REG_IER: n_rd = {1'b1, ier_q};
					default: n_rd = pa_read;
				endcase
			end
			via_pkg::OP_WRITE: begin
				unique case (reg_addr_s1)
					via_pkg::REG_PB: begin
						if ((pcr_q & 8'ha0) != 8'h20)
							n_ifr[via_pkg::FLAG_CB2] = 1'b0;
						n_ifr[via_pkg::FLAG_CB1] = 1'b0;
						n_out_b = write_data_s1;
					end
					via_pkg::REG_PA: begin
						if ((pcr_q & 8'h0a) != 8'h02)
							n_ifr[via_pkg::FLAG_CA2] = 1'b0;
						n_ifr[via_pkg::FLAG_CA1] = 1'b0;
						n_out_a = write_data_s1;
					end
					via_pkg::REG_DDRB: n_dir_b = write_data_s1;
					via_pkg::REG_DDRA: n_dir_a = write_data_s1;
					via_pkg::REG_T1CL, via_pkg::REG_T1LL: n_t1_latch[7:0] = write_data_s1;
					via_pkg::REG_T1CH: begin
						n_ifr[via_pkg::FLAG_T1] = 1'b0;
						n_t1_latch[15:8] = write_data_s1;
						n_t1_reload = 1'b1;
						n_t1_armed = 1'b1;
					end
					via_pkg::REG_T1LH: begin
						n_ifr[via_pkg::FLAG_T1] = 1'b0;
						n_t1_latch[15:8] = write_data_s1;
					end
					via_pkg::REG_T2CL: n_t2_latch_low = write_data_s1;
					via_pkg::REG_T2CH: begin
						n_ifr[via_pkg::FLAG_T2] = 1'b0;
						n_t2_count = {write_data_s1, t2_latch_low_q};
						if (!acr_q[5]) begin
							n_t2_armed = 1'b1;
							n_t2_count = {write_data_s1, t2_latch_low_q} + 16'd1;
						end
					end
					via_pkg::REG_SR: begin
						n_ifr[via_pkg::FLAG_SR] = 1'b0;
						if (acr_q[4:2] != via_pkg::SR_OFF)
							n_sr_start = 1'b1;
						n_sr_value = write_data_s1;
					end
					via_pkg::REG_ACR: begin
						if (write_data_s1[4:2] == via_pkg::SR_OFF) begin
							n_sr_left = 4'd0;
							n_sr_phase = 1'b1;
						end
						n_acr = write_data_s1;
					end
					via_pkg::REG_PCR: n_pcr = write_data_s1;
					via_pkg::REG_IFR: n_ifr = ifr_q & ~write_data_s1[6:0];
					via_pkg::REG_IER: begin
						if (write_data_s1[7])
							n_ier = ier_q | write_data_s1[6:0];
						else
							n_ier = ier_q & ~write_data_s1[6:0];
					end
					default: n_out_a = write_data_s1;
				endcase
			end
			default: begin
				// timer 1
				if (t1_reload_q) begin
					n_t1_count  = t1_latch_q;
					n_t1_reload = 1'b0;
				end else begin
					if (t1_count_q == 16'd0) begin
						n_t1_reload = 1'b1;
						if (t1_armed_q) begin
							n_ifr[via_pkg::FLAG_T1] = 1'b1;
							if (!acr_q[6])
								n_t1_armed = 1'b0;
						end
					end
					n_t1_count = t1_count_q - 16'd1;
				end

				// timer 2 and the shift clocks it drives
				if (t2_reload_q) begin
					n_t2_count[7:0] = t2_latch_low_q;
					if ((acr_q[4:2] == via_pkg::SR_FREE_T2) && (sr_left_q != 4'd0)) begin
						n_sr_phase = !sr_phase_q;
						if (!sr_phase_q) begin
							n_sr_value = {sr_value_q[6:0], sr_value_q[7]};
							n_sr_out   = sr_value_q[7];
						end
					end else if ((acr_q[3:2] == via_pkg::SR_CLK_T2) && (sr_left_q != 4'd0)) begin
						n_sr_phase = !sr_phase_q;
						if (!sr_phase_q) begin
							n_sr_value = {sr_value_q[6:0], acr_q[4] ? sr_value_q[7] : 1'b1};
							n_sr_out   = acr_q[4] ? sr_value_q[7] : 1'b1;
							n_sr_left  = left_dec;
							if (left_dec == 4'd0)
								n_ifr[via_pkg::FLAG_SR] = 1'b1;
						end
					end
					n_t2_reload = 1'b0;
				end else if (!acr_q[5]) begin
					if ((t2_count_q[7:0] == 8'd0) && ((acr_q & 8'h14) != 8'h00))
						n_t2_reload = 1'b1;
					if ((t2_count_q == 16'd0) && t2_armed_q) begin
						n_ifr[via_pkg::FLAG_T2] = 1'b1;
						n_t2_armed = 1'b0;
					end
					n_t2_count = t2_count_q - 16'd1;
				end

				// shift clocked by the system clock
				if ((sr_left_q != 4'd0) && (acr_q[3:2] == via_pkg::SR_CLK_SYS)) begin
					n_sr_phase = !sr_phase_q;
					if (!sr_phase_q) begin
						n_sr_value = {sr_value_q[6:0], acr_q[4] ? sr_value_q[7] : 1'b1};
						n_sr_out   = acr_q[4] ? sr_value_q[7] : 1'b1;
						n_sr_left  = left_dec;
						if (left_dec == 4'd0)
							n_ifr[via_pkg::FLAG_SR] = 1'b1;
					end
				end

				if (sr_start_q) begin
					n_sr_start = 1'b0;
					n_sr_left  = acr_q[4] ? via_pkg::SHIFT_OUT_COUNT : via_pkg::SHIFT_IN_COUNT;
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1     <= opcode;
			reg_addr_s1   <= reg_addr;
			write_data_s1 <= write_data;
			pa_s1         <= port_a_pins;
			pb_s1         <= port_b_pins;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_a_q        <= 8'h00;
			dir_b_q        <= 8'h00;
			out_a_q        <= 8'h00;
			out_b_q        <= 8'h00;
			t1_count_q     <= via_pkg::TIMER_RESET;
			t1_latch_q     <= via_pkg::TIMER_RESET;
			t2_count_q     <= via_pkg::TIMER_RESET;
			t1_reload_q    <= 1'b0;
			t1_armed_q     <= 1'b0;
			t2_reload_q    <= 1'b0;
			t2_armed_q     <= 1'b0;
			t2_latch_low_q <= via_pkg::LATCH_RESET;
			sr_value_q     <= 8'h00;
			sr_left_q      <= 4'd0;
			sr_start_q     <= 1'b0;
			acr_q          <= 8'h00;
			pcr_q          <= 8'h00;
			ifr_q          <= 7'h00;
			ier_q          <= 7'h00;
			sr_phase_q     <= 1'b1;
			sr_out_q       <= 1'b1;
		end else if (step) begin
			dir_a_q        <= n_dir_a;
			dir_b_q        <= n_dir_b;
			out_a_q        <= n_out_a;
			out_b_q        <= n_out_b;
			t1_count_q     <= n_t1_count;
			t1_latch_q     <= n_t1_latch;
			t2_count_q     <= n_t2_count;
			t1_reload_q    <= n_t1_reload;
			t1_armed_q     <= n_t1_armed;
			t2_reload_q    <= n_t2_reload;
			t2_armed_q     <= n_t2_armed;
			t2_latch_low_q <= n_t2_latch_low;
			sr_value_q     <= n_sr_value;
			sr_left_q      <= n_sr_left;
			sr_start_q     <= n_sr_start;
			acr_q          <= n_acr;
			pcr_q          <= n_pcr;
			ifr_q          <= n_ifr;
			ier_q          <= n_ier;
			sr_phase_q     <= n_sr_phase;
			sr_out_q       <= n_sr_out;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			read_data_s2 <= n_rd;
			irq_s2       <= |(n_ifr & n_ier);
			ca2_s2       <= n_pcr[3:1] != via_pkg::CA2_LOW_OUT;
		end
	end

	// port levels follow state, which only moves together with the result register
	assign out_valid    = valid_s2;
	assign read_data    = read_data_s2;
	assign irq          = irq_s2;
	assign port_a_drive = out_a_q;
	assign port_a_dir   = dir_a_q;
	assign port_b_drive = out_b_q;
	assign port_b_dir   = dir_b_q;
	assign ca2_level    = ca2_s2;
	assign cb2_level    = sr_out_q;

	a_sr_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		sr_left_q <= via_pkg::SHIFT_MAX_COUNT)
		else $error("shift count out of range");

	a_t1_reload_once: assert property (@(posedge clk) disable iff (!arst_n)
		(step && t1_reload_q && opcode_s1 != via_pkg::OP_READ
			&& opcode_s1 != via_pkg::OP_WRITE) |=> !t1_reload_q)
		else $error("timer 1 reload held past its tick");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(step && opcode_s1 != via_pkg::OP_READ) |=> read_data == 8'h00)
		else $error("read data not zero on tick or write");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	a_irq_match: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> irq == (|(ifr_q & ier_q)))
		else $error("irq out of step with flags");

endmodule
